// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked on every rising edge outside reset.
`define CPR_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("assertion failed");

// Property that must hold in the cycle after the trigger.
`define CPR_ASSERT_NEXT(lbl, clk_s, rstn_s, trig, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (trig) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/cpr_pkg.sv =====
// Shared constants and controller/datapath interface types for the clock replacement core.
package cpr_pkg;

  localparam int FRAMES    = 8;
  localparam int PAGE_BITS = 16;
  localparam int FIDX_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W     = $clog2(FRAMES + 1);
  localparam int AF_W      = 4;
  localparam int PN_W      = 16;
  localparam int FI_W      = 3;
  localparam int FC_W      = 32;

  typedef struct packed {
    logic load;
    logic lookup;
    logic sweep;
    logic emit;
  } cpr_cmd_t;

  typedef struct packed {
    logic hit;
    logic ref_set;
  } cpr_sts_t;

endpackage

// ===== sv/cpr_ctrl.sv =====
// Sequencer for one page reference: accept, lookup, clock sweep, result hand-off.
module cpr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_free,
  input  cpr_pkg::cpr_sts_t sts,
  output cpr_pkg::cpr_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LOOK  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.lookup = 1'b1;
        state_nxt  = sts.hit ? S_DONE : S_SWEEP;
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (!sts.ref_set) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/cpr_dp.sv =====
// Frame table, clock hand, fault counter and result registers.
module cpr_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cpr_pkg::cpr_cmd_t                 cmd,
  output cpr_pkg::cpr_sts_t                 sts,
  input  logic [cpr_pkg::CNT_W-1:0]         n_use,
  input  logic [cpr_pkg::PN_W-1:0]          in_page_number,
  output logic                              out_hit,
  output logic [cpr_pkg::FI_W-1:0]          out_frame_index,
  output logic                              out_evicted_valid,
  output logic [cpr_pkg::PN_W-1:0]          out_evicted_page,
  output logic [cpr_pkg::FC_W-1:0]          out_faults_so_far
);

  localparam int FR  = cpr_pkg::FRAMES;
  localparam int PB  = cpr_pkg::PAGE_BITS;
  localparam int FW  = cpr_pkg::FIDX_W;
  localparam int CW  = cpr_pkg::CNT_W;

  logic [PB-1:0] page_r, page_nxt;
  logic [PB-1:0] fpage_r [FR];
  logic [PB-1:0] fpage_nxt [FR];
  logic [FR-1:0] fvalid_r, fvalid_nxt;
  logic [FR-1:0] ref_r, ref_nxt;
  logic [FW-1:0] hand_r, hand_nxt;
  logic [cpr_pkg::FC_W-1:0] fault_r, fault_nxt;

  logic          res_hit_r, res_hit_nxt;
  logic [FW-1:0] res_slot_r, res_slot_nxt;
  logic          res_ev_r, res_ev_nxt;
  logic [PB-1:0] res_evp_r, res_evp_nxt;

  logic                     o_hit_r, o_hit_nxt;
  logic [cpr_pkg::FI_W-1:0] o_idx_r, o_idx_nxt;
  logic                     o_ev_r, o_ev_nxt;
  logic [cpr_pkg::PN_W-1:0] o_evp_r, o_evp_nxt;
  logic [cpr_pkg::FC_W-1:0] o_flt_r, o_flt_nxt;

  logic          hit;
  logic [FW-1:0] slot;
  logic [FW-1:0] hand_eff;

  function automatic logic [FW-1:0] next_frame(input logic [FW-1:0] f,
                                               input logic [CW-1:0] n);
    logic [CW-1:0] s;
    s = CW'(f) + CW'(1);
    return (s >= n) ? '0 : FW'(s);
  endfunction

  assign hand_eff = (CW'(hand_r) >= n_use) ? '0 : hand_r;

  always_comb begin
    hit  = 1'b0;
    slot = '0;
    for (int i = FR - 1; i >= 0; i--) begin
      if (fvalid_r[i] && (fpage_r[i] == page_r) && (32'(i) < 32'(n_use))) begin
        hit  = 1'b1;
        slot = FW'(i);
      end
    end
  end

  assign sts.hit     = hit;
  assign sts.ref_set = ref_r[hand_r];

  always_comb begin
    page_nxt     = page_r;
    fpage_nxt    = fpage_r;
    fvalid_nxt   = fvalid_r;
    ref_nxt      = ref_r;
    hand_nxt     = hand_r;
    fault_nxt    = fault_r;
    res_hit_nxt  = res_hit_r;
    res_slot_nxt = res_slot_r;
    res_ev_nxt   = res_ev_r;
    res_evp_nxt  = res_evp_r;
    o_hit_nxt    = o_hit_r;
    o_idx_nxt    = o_idx_r;
    o_ev_nxt     = o_ev_r;
    o_evp_nxt    = o_evp_r;
    o_flt_nxt    = o_flt_r;

    if (cmd.load) begin
      page_nxt = PB'(in_page_number);
    end

    if (cmd.lookup) begin
      if (hit) begin
        ref_nxt[slot] = 1'b1;
        hand_nxt      = next_frame(slot, n_use);
        res_hit_nxt   = 1'b1;
        res_slot_nxt  = slot;
        res_ev_nxt    = 1'b0;
        res_evp_nxt   = '0;
      end else begin
        hand_nxt = hand_eff;
      end
    end

    if (cmd.sweep) begin
      if (ref_r[hand_r]) begin
        ref_nxt[hand_r] = 1'b0;
        hand_nxt        = next_frame(hand_r, n_use);
      end else begin
        res_hit_nxt       = 1'b0;
        res_slot_nxt      = hand_r;
        res_ev_nxt        = fvalid_r[hand_r];
        res_evp_nxt       = fvalid_r[hand_r] ? fpage_r[hand_r] : '0;
        fpage_nxt[hand_r] = page_r;
        fvalid_nxt[hand_r] = 1'b1;
        ref_nxt[hand_r]   = 1'b1;
        hand_nxt          = next_frame(hand_r, n_use);
        fault_nxt         = (fault_r == '1) ? fault_r : fault_r + cpr_pkg::FC_W'(1);
      end
    end

    if (cmd.emit) begin
      o_hit_nxt = res_hit_r;
      o_idx_nxt = cpr_pkg::FI_W'(res_slot_r);
      o_ev_nxt  = res_ev_r;
      o_evp_nxt = cpr_pkg::PN_W'(res_evp_r);
      o_flt_nxt = fault_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fvalid_r <= '0;
      ref_r    <= '0;
      hand_r   <= '0;
      fault_r  <= '0;
    end else begin
      fvalid_r <= fvalid_nxt;
      ref_r    <= ref_nxt;
      hand_r   <= hand_nxt;
      fault_r  <= fault_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r     <= page_nxt;
    fpage_r    <= fpage_nxt;
    res_hit_r  <= res_hit_nxt;
    res_slot_r <= res_slot_nxt;
    res_ev_r   <= res_ev_nxt;
    res_evp_r  <= res_evp_nxt;
    o_hit_r    <= o_hit_nxt;
    o_idx_r    <= o_idx_nxt;
    o_ev_r     <= o_ev_nxt;
    o_evp_r    <= o_evp_nxt;
    o_flt_r    <= o_flt_nxt;
  end

  assign out_hit           = o_hit_r;
  assign out_frame_index   = o_idx_r;
  assign out_evicted_valid = o_ev_r;
  assign out_evicted_page  = o_evp_r;
  assign out_faults_so_far = o_flt_r;

endmodule

// ===== sv/clock_page_replacement_core.sv =====
// Top level of the clock (second-chance) page replacement core.
//
//  channel  direction  handshake            payload
//  in_      input      in_valid/in_ready    in_page_number
//  out_     output     out_valid/out_ready  hit, frame_index, evicted_valid/page, faults
//  cfg      APB write  psel/penable/pready  active_frames at address 0
//
// A hit runs from accept to the next accept through accept, lookup, hand-off.
// A miss runs through accept, lookup, k sweep steps that each clear one reference
// bit, one placement step, hand-off; k runs from 0 to the active frame count.
// Reset: all frames empty, hand at 0, fault count 0, active frames 8.
// A result held by out_ready low stays in the output register; the next item
// is still accepted and its result waits until the register is free.
`include "assert_macros.svh"

module clock_page_replacement_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cpr_pkg::PN_W-1:0]          in_page_number,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hit,
  output logic [cpr_pkg::FI_W-1:0]          out_frame_index,
  output logic                              out_evicted_valid,
  output logic [cpr_pkg::PN_W-1:0]          out_evicted_page,
  output logic [cpr_pkg::FC_W-1:0]          out_faults_so_far,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [1:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int CW = cpr_pkg::CNT_W;

  logic [cpr_pkg::AF_W-1:0] af_r, af_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [CW-1:0]            n_use;
  logic                     out_free;
  cpr_pkg::cpr_cmd_t        cmd;
  cpr_pkg::cpr_sts_t        sts;

  assign pready = 1'b1;
  assign prdata = 32'(af_r);

  always_comb begin
    af_nxt = af_r;
    if (psel && penable && pwrite && (paddr == 2'd0)) begin
      af_nxt = pwdata[cpr_pkg::AF_W-1:0];
    end
  end

  always_comb begin
    if (af_r == '0) begin
      n_use = CW'(1);
    end else if (32'(af_r) > 32'(cpr_pkg::FRAMES)) begin
      n_use = CW'(cpr_pkg::FRAMES);
    end else begin
      n_use = CW'(af_r);
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      af_r        <= 4'd8;
      out_valid_r <= 1'b0;
    end else begin
      af_r        <= af_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  cpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  cpr_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .n_use             (n_use),
    .in_page_number    (in_page_number),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_faults_so_far (out_faults_so_far)
  );

  `CPR_ASSERT(a_hit_no_evict, clk, rst_n, (out_valid && out_hit) |-> !out_evicted_valid)
  `CPR_ASSERT(a_evp_zero, clk, rst_n, (out_valid && !out_evicted_valid) |-> (out_evicted_page == '0))
  `CPR_ASSERT(a_miss_counted, clk, rst_n, (out_valid && !out_hit) |-> (out_faults_so_far != '0))
  `CPR_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule
